/* sv/pts_pkg.sv */
// Shared types, constants and codes for the periodic task scheduler
package pts_pkg;

    localparam int TASK_SLOTS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_POP         = 64;

    localparam int IN_DATA_W  = 176;   // 3+32+64+64+7 = 170 -> 176
    localparam int OUT_DATA_W = 176;   // 1+32+64+64+5+7+1 = 174 -> 176

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INFO   = 3'd2,
        OP_COUNT  = 3'd3,
        OP_UPDATE = 3'd4,
        OP_POP    = 3'd5,
        OP_RSV6   = 3'd6,
        OP_RSV7   = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD_SCAN,
        ST_UPD_APPLY,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_EMIT,
        ST_HOLD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic scan_clr;    // restart slot scan
        logic scan_step;   // evaluate one slot
        logic do_add;
        logic do_remove;
        logic upd_clr;     // reset update counters
        logic upd_apply;   // push best; advance it, or free it if its period is zero
        logic upd_held;
        logic pop_rd;      // issue FIFO read
        logic pop_take;    // capture FIFO data, advance head
        logic res_load;    // build result register
        logic res_last;
    } pts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic   scan_done;
        logic   best_found;
        logic   fifo_full;
        logic   pop_more;   // another id remains to pop
        op_t    op;
    } pts_sts_t;

endpackage

/* sv/pts_ram.sv */
// Generic single-port-write, registered-read RAM
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* sv/pts_ctrl.sv */
// Sequencer for the periodic task scheduler operations
module pts_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                res_valid,
    input  logic                res_ready,
    input  pts_pkg::pts_sts_t   sts,
    output pts_pkg::pts_cmd_t   cmd
);
    pts_pkg::state_t state_reg, state_next;
    logic            pend_reg, pend_next;   // result register holds an item

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pts_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    assign res_valid = pend_reg;

    always_comb begin
        logic take;
        take       = pend_reg && res_ready;
        state_next = state_reg;
        pend_next  = pend_reg && !res_ready;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pts_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    cmd.upd_clr  = 1'b1;
                    state_next   = pts_pkg::ST_SCAN;
                end
            end
            pts_pkg::ST_SCAN: begin
                if (sts.op == pts_pkg::OP_POP) begin
                    state_next = pts_pkg::ST_POP_RD;
                end else if (sts.op == pts_pkg::OP_UPDATE) begin
                    state_next = pts_pkg::ST_UPD_SCAN;
                end else if (!sts.scan_done) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    state_next = pts_pkg::ST_EMIT;
                end
            end
            pts_pkg::ST_UPD_SCAN: begin
                if (!sts.scan_done) begin
                    cmd.scan_step = 1'b1;
                end else if (!sts.best_found) begin
                    state_next = pts_pkg::ST_EMIT;
                end else if (sts.fifo_full) begin
                    cmd.upd_held = 1'b1;
                    state_next   = pts_pkg::ST_EMIT;
                end else begin
                    state_next = pts_pkg::ST_UPD_APPLY;
                end
            end
            pts_pkg::ST_UPD_APPLY: begin
                cmd.upd_apply = 1'b1;
                cmd.scan_clr  = 1'b1;
                state_next    = pts_pkg::ST_UPD_SCAN;
            end
            pts_pkg::ST_POP_RD: begin
                if (sts.pop_more) begin
                    cmd.pop_rd = 1'b1;
                    state_next = pts_pkg::ST_POP_WAIT;
                end else begin
                    state_next = pts_pkg::ST_EMIT;
                end
            end
            pts_pkg::ST_POP_WAIT: begin
                // wait for the output register to be free
                if (!pend_reg || take) begin
                    cmd.pop_take = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_last = 1'b1;   // datapath clears when more remain
                    pend_next    = 1'b1;
                    state_next   = pts_pkg::ST_HOLD;
                end
            end
            pts_pkg::ST_HOLD: begin
                // last pop result decides end of item
                state_next = sts.pop_more ? pts_pkg::ST_POP_RD : pts_pkg::ST_IDLE;
            end
            pts_pkg::ST_EMIT: begin
                // table change and result build share one edge
                if (!pend_reg || take) begin
                    cmd.do_add    = (sts.op == pts_pkg::OP_ADD);
                    cmd.do_remove = (sts.op == pts_pkg::OP_REMOVE);
                    cmd.res_load  = 1'b1;
                    cmd.res_last  = 1'b1;
                    pend_next     = 1'b1;
                    state_next    = pts_pkg::ST_IDLE;
                end
            end
            default: state_next = pts_pkg::ST_IDLE;
        endcase
    end
endmodule

/* sv/pts_dp.sv */
// Task table, ready FIFO and result register of the scheduler
module pts_dp #(
    parameter int TASK_SLOTS  = pts_pkg::TASK_SLOTS_DEF,
    parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [2:0]          in_op,
    input  logic [31:0]         in_task_id,
    input  logic [63:0]         in_period,
    input  logic [63:0]         in_time,
    input  logic [6:0]          in_pop_limit,
    input  pts_pkg::pts_cmd_t   cmd,
    output pts_pkg::pts_sts_t   sts,
    output logic                res_ok,
    output logic [31:0]         res_id,
    output logic [63:0]         res_period,
    output logic [63:0]         res_next_run,
    output logic [4:0]          res_count,
    output logic [6:0]          res_queued,
    output logic                res_held,
    output logic                res_last
);
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    // captured item
    pts_pkg::op_t op_reg;
    logic [31:0]  tid_reg;
    logic [63:0]  per_reg, time_reg;
    logic [6:0]   lim_reg;

    // task table
    logic [TASK_SLOTS-1:0] valid_reg;
    logic [31:0]           sid_reg  [TASK_SLOTS];
    logic [63:0]           sper_reg [TASK_SLOTS];
    logic [63:0]           snext_reg[TASK_SLOTS];
    logic [31:0]           idc_reg;
    logic [CW-1:0]         live_reg;

    // scan state
    logic [SW:0]   idx_reg;
    logic          hit_reg;
    logic [SW-1:0] hit_slot_reg;
    logic          free_ok_reg;
    logic [SW-1:0] free_slot_reg;

    // fifo state
    logic [QW-1:0] head_reg, tail_reg;
    logic [FW-1:0] fill_reg;
    logic [6:0]    pushed_reg, popn_reg;
    logic          held_reg;
    logic [31:0]   fifo_rd;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= pts_pkg::op_t'(in_op);
            tid_reg  <= in_task_id;
            per_reg  <= in_period;
            time_reg <= in_time;
            lim_reg  <= (in_pop_limit > 7'(pts_pkg::MAX_POP)) ?
                        7'(pts_pkg::MAX_POP) : in_pop_limit;
        end
    end

    // one slot evaluated per cycle
    logic [SW-1:0] cur;
    logic          cand_due, cand_better;
    assign cur      = idx_reg[SW-1:0];
    assign cand_due = valid_reg[cur] && (snext_reg[cur] <= time_reg);
    assign cand_better = !hit_reg ||
        (snext_reg[cur] < snext_reg[hit_slot_reg]) ||
        ((snext_reg[cur] == snext_reg[hit_slot_reg]) &&
         (sid_reg[cur] < sid_reg[hit_slot_reg]));

    assign sts.scan_done  = (idx_reg == (SW+1)'(TASK_SLOTS));
    assign sts.best_found = hit_reg;
    assign sts.fifo_full  = (fill_reg == FW'(QUEUE_DEPTH));
    assign sts.pop_more   = (popn_reg != '0);
    assign sts.op         = op_reg;

    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + 1'b1;
            if (op_reg == pts_pkg::OP_UPDATE) begin
                if (cand_due && cand_better) begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= cur;
                end
            end else if (valid_reg[cur] && sid_reg[cur] == tid_reg && !hit_reg) begin
                hit_reg      <= 1'b1;
                hit_slot_reg <= cur;
            end
            if (!valid_reg[cur] && !free_ok_reg) begin
                free_ok_reg   <= 1'b1;
                free_slot_reg <= cur;
            end
        end
    end

    // saturating advance of the chosen task
    logic [64:0] adv_sum;
    assign adv_sum = {1'b0, snext_reg[hit_slot_reg]} + {1'b0, sper_reg[hit_slot_reg]};
    logic add_ok;
    assign add_ok = free_ok_reg && (idc_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            idc_reg   <= 32'd1;
            live_reg  <= '0;
        end else if (cmd.do_add && add_ok) begin
            valid_reg[free_slot_reg] <= 1'b1;
            idc_reg                  <= idc_reg + 32'd1;
            live_reg                 <= live_reg + 1'b1;
        end else if (cmd.do_remove && hit_reg) begin
            valid_reg[hit_slot_reg] <= 1'b0;
            live_reg                <= live_reg - 1'b1;
        end else if (cmd.upd_apply && sper_reg[hit_slot_reg] == '0) begin
            valid_reg[hit_slot_reg] <= 1'b0;
            live_reg                <= live_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_add && add_ok) begin
            sid_reg[free_slot_reg]   <= idc_reg;
            sper_reg[free_slot_reg]  <= per_reg;
            snext_reg[free_slot_reg] <= time_reg;
        end else if (cmd.upd_apply && sper_reg[hit_slot_reg] != '0) begin
            snext_reg[hit_slot_reg] <= adv_sum[64] ? '1 : adv_sum[63:0];
        end
    end

    // ready fifo pointers and per-item counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (cmd.upd_apply) begin
                tail_reg <= (tail_reg == QW'(QUEUE_DEPTH-1)) ? '0 : tail_reg + 1'b1;
            end
            if (cmd.pop_take) begin
                head_reg <= (head_reg == QW'(QUEUE_DEPTH-1)) ? '0 : head_reg + 1'b1;
            end
            fill_reg <= fill_reg + FW'(cmd.upd_apply) - FW'(cmd.pop_take);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_clr) begin
            pushed_reg <= '0;
            held_reg   <= 1'b0;
            popn_reg   <= '0;
        end else begin
            if (cmd.upd_apply) pushed_reg <= pushed_reg + 7'd1;
            if (cmd.upd_held)  held_reg   <= 1'b1;
            if (op_reg == pts_pkg::OP_POP && cmd.scan_step == 1'b0 &&
                popn_reg == '0 && pushed_reg == '0) begin
                // size the pop once, flagged through pushed_reg
                popn_reg   <= (7'(fill_reg) < lim_reg) ? 7'(fill_reg) : lim_reg;
                pushed_reg <= 7'd1;
            end else if (cmd.pop_take) begin
                popn_reg <= popn_reg - 7'd1;
            end
        end
    end

    pts_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk    (aclk),
        .wr_en   (cmd.upd_apply),
        .wr_addr (tail_reg),
        .wr_data (sid_reg[hit_slot_reg]),
        .rd_addr (head_reg),
        .rd_data (fifo_rd)
    );

    // result register; live count reflects the table after the operation
    logic [CW-1:0] live_after;
    always_comb begin
        live_after = live_reg;
        if (cmd.do_add && add_ok)             live_after = live_reg + 1'b1;
        else if (cmd.do_remove && hit_reg)    live_after = live_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_ok       <= 1'b0;
            res_id       <= '0;
            res_period   <= '0;
            res_next_run <= '0;
            res_count    <= 5'(live_after);
            res_queued   <= '0;
            res_held     <= 1'b0;
            res_last     <= cmd.res_last;
            unique case (op_reg)
                pts_pkg::OP_ADD: begin
                    res_ok <= add_ok;
                    res_id <= add_ok ? idc_reg : '0;
                end
                pts_pkg::OP_REMOVE: res_ok <= hit_reg;
                pts_pkg::OP_INFO: begin
                    res_ok <= hit_reg;
                    if (hit_reg) begin
                        res_id       <= sid_reg[hit_slot_reg];
                        res_period   <= sper_reg[hit_slot_reg];
                        res_next_run <= snext_reg[hit_slot_reg];
                    end
                end
                pts_pkg::OP_COUNT: res_ok <= 1'b1;
                pts_pkg::OP_UPDATE: begin
                    res_ok     <= 1'b1;
                    res_queued <= pushed_reg;
                    res_held   <= held_reg;
                end
                pts_pkg::OP_POP: begin
                    res_ok   <= cmd.pop_take;
                    res_id   <= cmd.pop_take ? fifo_rd : '0;
                    res_last <= !cmd.pop_take || (popn_reg == 7'd1);
                end
                default: res_ok <= 1'b0;
            endcase
        end
    end
endmodule

/* sv/periodic_task_scheduler.sv */
// Top level of the periodic task scheduler: controller, datapath, stream ports
//
//  channel | dir | handshake       | payload
//  s_      | in  | tvalid/tready   | tdata: op, task_id, period, time_ms, pop_limit
//  m_      | out | tvalid/tready   | tdata: ok..held_back, tlast: last
//
// One item is taken at a time. Add, remove, info and count scan the table, one
// slot per cycle, then emit a result. Update repeats the scan and pushes the
// best due id until none is due or the FIFO is full, then emits its result. Pop
// reads each id through the FIFO RAM's registered read. Reset clears the task
// table at once; stalls on m_ hold the result register and the sequencer.
module periodic_task_scheduler #(
    parameter int TASK_SLOTS  = pts_pkg::TASK_SLOTS_DEF,
    parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] operation, [34:3] task_id, [98:35] period,
    // [162:99] time_ms, [169:163] pop_limit, rest zero
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] ok, [32:1] result_id, [96:33] period_out, [160:97] next_run_out,
    // [165:161] task_count, [172:166] queued, [173] held_back, rest zero
    output logic [175:0] m_tdata,
    output logic         m_tlast
);
    pts_pkg::pts_cmd_t cmd;
    pts_pkg::pts_sts_t sts;
    logic        r_ok, r_held;
    logic [31:0] r_id;
    logic [63:0] r_per, r_nxt;
    logic [4:0]  r_cnt;
    logic [6:0]  r_q;

    pts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pts_dp #(.TASK_SLOTS(TASK_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_op        (s_tdata[2:0]),
        .in_task_id   (s_tdata[34:3]),
        .in_period    (s_tdata[98:35]),
        .in_time      (s_tdata[162:99]),
        .in_pop_limit (s_tdata[169:163]),
        .cmd          (cmd),
        .sts          (sts),
        .res_ok       (r_ok),
        .res_id       (r_id),
        .res_period   (r_per),
        .res_next_run (r_nxt),
        .res_count    (r_cnt),
        .res_queued   (r_q),
        .res_held     (r_held),
        .res_last     (m_tlast)
    );

    assign m_tdata = {2'b00, r_held, r_q, r_cnt, r_nxt, r_per, r_id, r_ok};
endmodule

/* sv/pts_checker.sv */
// Port-level checker for the periodic task scheduler, bound to the top level
module pts_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [175:0] m_tdata,
    input logic         m_tlast
);
    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed under stall");

    // no new item is taken in the cycle after one was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

    // a failed result ends its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tlast)
        else $error("failed result not last");

    // task count never exceeds the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[165:161] <= 5'd16)
        else $error("task count out of range");
endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* sim/periodic_task_scheduler_test.sv */
// Testbench for the periodic task scheduler: directed table, random traffic, scoreboard
module periodic_task_scheduler_test;

    localparam int SLOTS = 16;
    localparam int DEPTH = 64;

    typedef struct packed {
        logic        ok;
        logic [31:0] rid;
        logic [63:0] per;
        logic [63:0] nxt;
        logic [4:0]  cnt;
        logic [6:0]  queued;
        logic        held;
        logic        last;
    } sched_res_t;

    typedef struct {
        pts_pkg::op_t op;
        logic [31:0]  tid;
        logic [63:0]  period;
        logic [63:0]  tnow;
        logic [6:0]   limit;
        logic         has_exp;   // typed-in expectation present
        logic         exp_ok;
        logic [31:0]  exp_id;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic         m_tlast;

    periodic_task_scheduler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_id [SLOTS];
    logic [63:0] tbl_period [SLOTS];
    logic [63:0] tbl_next [SLOTS];
    logic [31:0] next_id;
    logic [31:0] ready_ids [$];

    sched_res_t  pending_results [$];
    stim_row_t   directed [$];
    int          errors = 0;
    bit          rx_hold = 1'b0;
    bit          no_idle = 1'b0;
    event        start_hold;

    function automatic logic [4:0] live_tasks();
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < SLOTS; i++) n += tbl_valid[i];
        return n;
    endfunction

    function automatic sched_res_t mk_res(logic ok, logic [31:0] rid, logic [63:0] per,
                                          logic [63:0] nxt, logic [6:0] q, logic held,
                                          logic last);
        sched_res_t r;
        r.ok = ok; r.rid = rid; r.per = per; r.nxt = nxt; r.cnt = live_tasks();
        r.queued = q; r.held = held; r.last = last;
        return r;
    endfunction

    // append one expected result
    function automatic void expect_res(sched_res_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // compute the results of one accepted item, update predictor state
    task automatic schedule_item(input stim_row_t it);
        int s, best, n;
        logic [6:0] pushed;
        logic held;
        logic [63:0] sum;
        s = -1;
        case (it.op)
            pts_pkg::OP_ADD: begin
                for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
                if (s < 0 || next_id == 0) begin
                    expect_res(mk_res(0, 0, 0, 0, 0, 0, 1));
                end else begin
                    tbl_valid[s] = 1; tbl_id[s] = next_id;
                    tbl_period[s] = it.period; tbl_next[s] = it.tnow;
                    expect_res(mk_res(1, next_id, 0, 0, 0, 0, 1));
                    next_id++;
                end
            end
            pts_pkg::OP_REMOVE, pts_pkg::OP_INFO: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_valid[i] && tbl_id[i] == it.tid) s = i;
                if (s < 0)
                    expect_res(mk_res(0, 0, 0, 0, 0, 0, 1));
                else if (it.op == pts_pkg::OP_REMOVE) begin
                    tbl_valid[s] = 0;
                    expect_res(mk_res(1, 0, 0, 0, 0, 0, 1));
                end else
                    expect_res(mk_res(1, tbl_id[s], tbl_period[s], tbl_next[s], 0, 0, 1));
            end
            pts_pkg::OP_COUNT: expect_res(mk_res(1, 0, 0, 0, 0, 0, 1));
            pts_pkg::OP_UPDATE: begin
                pushed = 0; held = 0;
                forever begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!tbl_valid[i] || tbl_next[i] > it.tnow) continue;
                        if (best < 0 || tbl_next[i] < tbl_next[best] ||
                            (tbl_next[i] == tbl_next[best] && tbl_id[i] < tbl_id[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    if (ready_ids.size() >= DEPTH) begin
                        held = 1;
                        break;
                    end
                    ready_ids.insert(ready_ids.size(), tbl_id[best]);
                    pushed++;
                    if (tbl_period[best] == 0) tbl_valid[best] = 0;
                    else begin
                        sum = tbl_next[best] + tbl_period[best];
                        if (sum < tbl_next[best]) sum = '1;
                        tbl_next[best] = sum;
                    end
                end
                expect_res(mk_res(1, 0, 0, 0, pushed, held, 1));
            end
            pts_pkg::OP_POP: begin
                n = (it.limit > pts_pkg::MAX_POP) ? pts_pkg::MAX_POP : it.limit;
                if (n > ready_ids.size()) n = ready_ids.size();
                if (n == 0) expect_res(mk_res(0, 0, 0, 0, 0, 0, 1));
                for (int k = 0; k < n; k++)
                    expect_res(mk_res(1, ready_ids.pop_front(), 0, 0, 0, 0, k == n - 1));
            end
            default: expect_res(mk_res(0, 0, 0, 0, 0, 0, 1));
        endcase
    endtask

    // drive one item and wait for its acceptance
    task automatic send_item(input stim_row_t it);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.limit, it.tnow, it.period, it.tid, it.op};
        do @(posedge aclk); while (!s_tready);
        schedule_item(it);
        // rows with a typed-in expectation give exactly one result
        if (it.has_exp && (pending_results[$].ok !== it.exp_ok ||
                           pending_results[$].rid !== it.exp_id)) begin
            $display("%0t: table expectation ok/id %b/%h, predicted %b/%h", $time,
                     it.exp_ok, it.exp_id, pending_results[$].ok,
                     pending_results[$].rid);
            errors++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic stim_row_t row(pts_pkg::op_t op, logic [31:0] tid, logic [63:0] per,
                                      logic [63:0] t, logic [6:0] lim);
        stim_row_t r;
        r.op = op; r.tid = tid; r.period = per; r.tnow = t; r.limit = lim;
        r.has_exp = 0; r.exp_ok = 0; r.exp_id = 0;
        return r;
    endfunction

    function automatic stim_row_t row_e(stim_row_t r, logic ok, logic [31:0] id);
        r.has_exp = 1; r.exp_ok = ok; r.exp_id = id;
        return r;
    endfunction

    function automatic void put_row(stim_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic stim_row_t random_item(logic [63:0] clock_ms);
        stim_row_t r;
        int pick;
        r = row(pts_pkg::OP_COUNT, $urandom, 0, 0, 0);
        pick = $urandom_range(99);
        if (pick < 30) begin
            r.op = pts_pkg::OP_ADD;
            r.period = ($urandom_range(9) == 0) ? rand64() : $urandom_range(60);
            r.tnow = ($urandom_range(19) == 0) ? rand64() : clock_ms + $urandom_range(50);
        end else if (pick < 40) begin
            r.op = pts_pkg::OP_REMOVE;
            r.tid = ($urandom_range(3) == 0) ? $urandom : next_id - $urandom_range(1, 20);
        end else if (pick < 50) begin
            r.op = pts_pkg::OP_INFO;
            r.tid = ($urandom_range(3) == 0) ? $urandom : next_id - $urandom_range(1, 20);
        end else if (pick < 53) r.op = pts_pkg::OP_COUNT;
        else if (pick < 75) begin
            r.op = pts_pkg::OP_UPDATE;
            r.tnow = ($urandom_range(29) == 0) ? rand64() : clock_ms;
        end else if (pick < 97) begin
            r.op = pts_pkg::OP_POP;
            r.limit = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                               : 7'($urandom_range(8));
        end else r.op = pts_pkg::op_t'($urandom_range(6, 7));
        if ($urandom_range(9) == 0) r.limit = 7'($urandom);
        return r;
    endfunction

    // receiver: random stalls, long hold when asked
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 34);
    end

    // long receiver hold, counted here while the sender keeps offering items
    always @(start_hold) begin
        rx_hold = 1'b1;
        repeat (400) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // result checker
    always @(posedge aclk) begin
        sched_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[32:1], m_tdata[96:33], m_tdata[160:97],
                   m_tdata[165:161], m_tdata[172:166], m_tdata[173], m_tlast};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[175:174] !== 2'b00) begin
                    $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                    $display("  ok %b/%b id %h/%h per %h/%h nxt %h/%h", want.ok, got.ok,
                             want.rid, got.rid, want.per, got.per, want.nxt, got.nxt);
                    $display("  cnt %0d/%0d q %0d/%0d held %b/%b last %b/%b", want.cnt,
                             got.cnt, want.queued, got.queued, want.held, got.held,
                             want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #20000000;
        $display("periodic_task_scheduler_test: FAIL");
        $finish;
    end

    logic [63:0] clock_ms;

    initial begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 0;
        next_id = 1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table cases, extremes, every operation
        put_row(row_e(row(pts_pkg::OP_COUNT, 0, 0, 0, 0), 1, 0));
        put_row(row_e(row(pts_pkg::OP_POP, 0, 0, 0, 7'd64), 0, 0));
        put_row(row_e(row(pts_pkg::OP_INFO, 32'hFFFF_FFFF, 0, 0, 0), 0, 0));
        put_row(row_e(row(pts_pkg::OP_REMOVE, 1, 0, 0, 0), 0, 0));
        put_row(row_e(row(pts_pkg::OP_ADD, 0, 0, 64'd5, 0), 1, 1));
        put_row(row_e(row(pts_pkg::OP_ADD, 0, '1, '1, 0), 1, 2));
        put_row(row_e(row(pts_pkg::OP_ADD, 0, 64'd3, 64'd5, 0), 1, 3));
        put_row(row_e(row(pts_pkg::OP_ADD, 0, '1 - 1, 64'd2, 0), 1, 4));
        put_row(row(pts_pkg::OP_INFO, 2, 0, 0, 0));
        put_row(row(pts_pkg::OP_UPDATE, 0, 0, 64'd10, 0));
        put_row(row(pts_pkg::OP_UPDATE, 0, 0, '1, 0));
        put_row(row(pts_pkg::OP_INFO, 4, 0, 0, 0));
        put_row(row(pts_pkg::OP_POP, 0, 0, 0, 7'd1));
        put_row(row(pts_pkg::OP_POP, 0, 0, 0, 7'd127));
        put_row(row_e(row(pts_pkg::OP_REMOVE, 2, 0, 0, 0), 1, 0));
        put_row(row_e(row(pts_pkg::OP_RSV6, '1, '1, '1, '1), 0, 0));
        put_row(row_e(row(pts_pkg::OP_RSV7, 0, 0, 0, 0), 0, 0));
        put_row(row(pts_pkg::OP_POP, 0, 0, 0, 7'd0));
        foreach (directed[i]) send_item(directed[i]);
        drain_results();

        // fill table: full-table add failure
        for (int i = 0; i < SLOTS + 1; i++) send_item(row(pts_pkg::OP_ADD, 0, 1, 0, 0));
        // overflow the ready queue so update holds back, while receiver stalls
        -> start_hold;
        for (int i = 0; i < 6; i++)
            send_item(row(pts_pkg::OP_UPDATE, 0, 0, 64'd3 + 4 * i, 0));
        drain_results();
        for (int i = 0; i < 3; i++) send_item(row(pts_pkg::OP_POP, 0, 0, 0, 7'd64));
        send_item(row(pts_pkg::OP_UPDATE, 0, 0, 64'd40, 0));
        drain_results();
        for (int i = 0; i < SLOTS + 1; i++)
            send_item(row(pts_pkg::OP_REMOVE, next_id - 1 - i, 0, 0, 0));

        // random traffic with a steadily advancing clock
        clock_ms = 100;
        for (int n = 0; n < 420; n++) begin
            no_idle = (n >= 200 && n < 260);
            clock_ms += $urandom_range(10);
            send_item(random_item(clock_ms));
            if (n % 120 == 119) drain_results();
        end
        no_idle = 0;
        drain_results();

        if (errors == 0 && pending_results.size() == 0) begin
            $display("periodic_task_scheduler_test: PASS");
        end else begin
            $display("periodic_task_scheduler_test: FAIL");
        end
        $finish;
    end
endmodule
